/* src/ccev_pkg.sv */
// Shared types, constants and fixed-point helpers for the cubic curve evaluator.
package ccev_pkg;

  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned T_W       = 13;
  localparam int unsigned FX_W      = 32;
  localparam int unsigned S_TDATA_W = 144;
  localparam int unsigned S_TUSER_W = 3;

  localparam logic [FX_W-1:0]        FX_ONE  = FX_W'(1) << FRAC_BITS;
  localparam logic signed [63:0]     FX_HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic [FX_W-1:0]        DIV6_RECIP = 32'hAAAA_AAAB;
  localparam int unsigned            DIV6_SHIFT = 34;

  typedef enum logic [2:0] {
    MODE_CR_POS = 3'd0,
    MODE_CR_DIR = 3'd1,
    MODE_BS_POS = 3'd2,
    MODE_BS_DIR = 3'd3,
    MODE_BZ_POS = 3'd4
  } mode_t;

  // control values, powers of t and u, Catmull-Rom coefficients
  typedef struct packed {
    mode_t           mode;
    logic [FX_W-1:0] p0;
    logic [FX_W-1:0] p1;
    logic [FX_W-1:0] p2;
    logic [FX_W-1:0] p3;
    logic [T_W-1:0]  t;
    logic [FX_W-1:0] u;
    logic [FX_W-1:0] t2;
    logic [FX_W-1:0] u2;
    logic [FX_W-1:0] k0;
    logic [FX_W-1:0] k1;
    logic [FX_W-1:0] k2;
    logic [FX_W-1:0] k3;
    logic [FX_W-1:0] lin;
    logic [FX_W-1:0] sq;
    logic [FX_W-1:0] hd;
  } basis_t;

  // second-level products
  typedef struct packed {
    mode_t           mode;
    logic [FX_W-1:0] p0;
    logic [FX_W-1:0] p1;
    logic [FX_W-1:0] p2;
    logic [FX_W-1:0] p3;
    logic [T_W-1:0]  t;
    logic [FX_W-1:0] t2;
    logic [FX_W-1:0] u2;
    logic [FX_W-1:0] t3;
    logic [FX_W-1:0] m1;
    logic [FX_W-1:0] m2;
    logic [FX_W-1:0] m3;
    logic [FX_W-1:0] k0;
    logic [FX_W-1:0] k3;
    logic [FX_W-1:0] hd;
  } pow_t;

  // four product pairs plus an additive term
  typedef struct packed {
    logic [FX_W-1:0] x0;
    logic [FX_W-1:0] x1;
    logic [FX_W-1:0] x2;
    logic [FX_W-1:0] x3;
    logic [FX_W-1:0] y0;
    logic [FX_W-1:0] y1;
    logic [FX_W-1:0] y2;
    logic [FX_W-1:0] y3;
    logic [FX_W-1:0] e;
    logic            div6;
  } ops_t;

  typedef struct packed {
    logic [FX_W-1:0] q0;
    logic [FX_W-1:0] q1;
    logic [FX_W-1:0] q2;
    logic [FX_W-1:0] q3;
    logic [FX_W-1:0] e;
    logic            div6;
  } prod_t;

  typedef struct packed {
    logic [FX_W-1:0] s;
    logic            div6;
  } sum_t;

  // rounded signed fixed-point multiply, wraps to 32 bits
  function automatic logic [FX_W-1:0] fmul(input logic signed [FX_W-1:0] a,
                                           input logic signed [FX_W-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p + FX_HALF;
    return p[FRAC_BITS+FX_W-1:FRAC_BITS];
  endfunction

  // signed divide by two, truncating toward zero
  function automatic logic [FX_W-1:0] half(input logic [FX_W-1:0] x);
    logic [FX_W-1:0] s;
    s = x + FX_W'(x[FX_W-1]);
    return {s[FX_W-1], s[FX_W-1:1]};
  endfunction

endpackage

/* src/ccev_front.sv */
// Front pipeline: basis powers, coefficients and second-level products.
module ccev_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ccev_pkg::mode_t            mode,
  input  logic [ccev_pkg::FX_W-1:0]  p0,
  input  logic [ccev_pkg::FX_W-1:0]  p1,
  input  logic [ccev_pkg::FX_W-1:0]  p2,
  input  logic [ccev_pkg::FX_W-1:0]  p3,
  input  logic [ccev_pkg::T_W-1:0]   t,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ccev_pkg::pow_t             out_data
);
  import ccev_pkg::*;

  basis_t          basis;
  basis_t          basis_next;
  logic            basis_valid;
  logic            basis_ready;
  pow_t            pow;
  pow_t            pow_next;
  logic            pow_valid;
  logic            pow_ready;

  logic [FX_W-1:0] tx;
  logic [FX_W-1:0] bt;
  logic [FX_W-1:0] a1, b1, a2, b2, a3, b3;

  assign tx = FX_W'(t);

  always_comb begin
    basis_next.mode = mode;
    basis_next.p0   = p0;
    basis_next.p1   = p1;
    basis_next.p2   = p2;
    basis_next.p3   = p3;
    basis_next.t    = t;
    basis_next.u    = FX_ONE - tx;
    basis_next.t2   = fmul(tx, tx);
    basis_next.u2   = fmul(FX_ONE - tx, FX_ONE - tx);
    basis_next.k0   = 32'd0 - 32'd3 * p0 + 32'd9 * p1 - 32'd9 * p2 + 32'd3 * p3;
    basis_next.k1   = 32'd6 * p0 - 32'd15 * p1 + 32'd12 * p2 - 32'd3 * p3;
    basis_next.k2   = 32'd3 * p2 - 32'd3 * p0;
    basis_next.k3   = 32'd6 * p1;
    basis_next.lin  = p0 - half(32'd5 * p1) + 32'd2 * p2 - half(p3);
    basis_next.sq   = half(p0) - half(32'd3 * p1) + half(32'd3 * p2) - half(p3);
    basis_next.hd   = half(p2) - half(p0);
  end

  assign basis_ready = !basis_valid || pow_ready;
  assign in_ready    = basis_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_valid <= 1'b0;
    end else if (basis_ready) begin
      basis_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (basis_ready && in_valid) begin
      basis <= basis_next;
    end
  end

  assign bt = FX_W'(basis.t);

  always_comb begin
    a1 = '0;
    b1 = '0;
    a2 = '0;
    b2 = '0;
    a3 = '0;
    b3 = '0;
    unique case (basis.mode)
      MODE_CR_POS: begin
        a1 = basis.k1;
        b1 = basis.t2;
        a2 = basis.k2;
        b2 = bt;
      end
      MODE_CR_DIR: begin
        a1 = bt;
        b1 = basis.lin;
        a2 = basis.t2;
        b2 = basis.sq;
      end
      MODE_BS_POS, MODE_BS_DIR: begin
        a1 = basis.u2;
        b1 = basis.u;
      end
      MODE_BZ_POS: begin
        a1 = basis.u2;
        b1 = basis.u;
        a2 = 32'd3 * bt;
        b2 = basis.u2;
        a3 = 32'd3 * basis.t2;
        b3 = basis.u;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pow_next.mode = basis.mode;
    pow_next.p0   = basis.p0;
    pow_next.p1   = basis.p1;
    pow_next.p2   = basis.p2;
    pow_next.p3   = basis.p3;
    pow_next.t    = basis.t;
    pow_next.t2   = basis.t2;
    pow_next.u2   = basis.u2;
    pow_next.t3   = fmul(basis.t2, bt);
    pow_next.m1   = fmul(a1, b1);
    pow_next.m2   = fmul(a2, b2);
    pow_next.m3   = fmul(a3, b3);
    pow_next.k0   = basis.k0;
    pow_next.k3   = basis.k3;
    pow_next.hd   = basis.hd;
  end

  assign pow_ready = !pow_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pow_valid <= 1'b0;
    end else if (pow_ready) begin
      pow_valid <= basis_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pow_ready && basis_valid) begin
      pow <= pow_next;
    end
  end

  assign out_valid = pow_valid;
  assign out_data  = pow;

endmodule

/* src/ccev_combine.sv */
// Middle pipeline: per-mode weights, final products and their sum.
module ccev_combine (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ccev_pkg::pow_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ccev_pkg::sum_t  out_data
);
  import ccev_pkg::*;

  ops_t            ops;
  ops_t            ops_next;
  logic            ops_valid;
  logic            ops_ready;
  prod_t           prod;
  prod_t           prod_next;
  logic            prod_valid;
  logic            prod_ready;
  sum_t            sum;
  sum_t            sum_next;
  logic            sum_valid;
  logic            sum_ready;

  logic [FX_W-1:0] tx;

  assign tx = FX_W'(in_data.t);

  always_comb begin
    ops_next = '0;
    unique case (in_data.mode)
      MODE_CR_POS: begin
        ops_next.x0   = in_data.k0;
        ops_next.y0   = in_data.t3;
        ops_next.e    = in_data.m1 + in_data.m2 + in_data.k3;
        ops_next.div6 = 1'b1;
      end
      MODE_CR_DIR: begin
        ops_next.e = in_data.hd + 32'd2 * in_data.m1 - 32'd3 * in_data.m2;
      end
      MODE_BS_POS: begin
        ops_next.x0   = in_data.p0;
        ops_next.x1   = in_data.p1;
        ops_next.x2   = in_data.p2;
        ops_next.x3   = in_data.p3;
        ops_next.y0   = in_data.m1;
        ops_next.y1   = 32'd3 * in_data.t3 - 32'd6 * in_data.t2 + 32'd4 * FX_ONE;
        ops_next.y2   = 32'd3 * (tx + in_data.t2 - in_data.t3) + FX_ONE;
        ops_next.y3   = in_data.t3;
        ops_next.div6 = 1'b1;
      end
      MODE_BS_DIR: begin
        ops_next.x0   = in_data.p0;
        ops_next.x1   = in_data.p1;
        ops_next.x2   = in_data.p2;
        ops_next.x3   = in_data.p3;
        ops_next.y0   = 32'd0 - 32'd3 * in_data.u2;
        ops_next.y1   = 32'd9 * in_data.t2 - 32'd12 * tx;
        ops_next.y2   = 32'd6 * tx - 32'd9 * in_data.t2 + 32'd3 * FX_ONE;
        ops_next.y3   = 32'd3 * in_data.t2;
        ops_next.div6 = 1'b1;
      end
      MODE_BZ_POS: begin
        ops_next.x0 = in_data.p0;
        ops_next.x1 = in_data.p1;
        ops_next.x2 = in_data.p2;
        ops_next.x3 = in_data.p3;
        ops_next.y0 = in_data.m1;
        ops_next.y1 = in_data.m2;
        ops_next.y2 = in_data.m3;
        ops_next.y3 = in_data.t3;
      end
      default: begin
      end
    endcase
  end

  assign ops_ready = !ops_valid || prod_ready;
  assign in_ready  = ops_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ops_valid <= 1'b0;
    end else if (ops_ready) begin
      ops_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ops_ready && in_valid) begin
      ops <= ops_next;
    end
  end

  always_comb begin
    prod_next.q0   = fmul(ops.x0, ops.y0);
    prod_next.q1   = fmul(ops.x1, ops.y1);
    prod_next.q2   = fmul(ops.x2, ops.y2);
    prod_next.q3   = fmul(ops.x3, ops.y3);
    prod_next.e    = ops.e;
    prod_next.div6 = ops.div6;
  end

  assign prod_ready = !prod_valid || sum_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= ops_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && ops_valid) begin
      prod <= prod_next;
    end
  end

  always_comb begin
    sum_next.s    = (prod.q0 + prod.q1) + (prod.q2 + prod.q3) + prod.e;
    sum_next.div6 = prod.div6;
  end

  assign sum_ready = !sum_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (sum_ready) begin
      sum_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && prod_valid) begin
      sum <= sum_next;
    end
  end

  assign out_valid = sum_valid;
  assign out_data  = sum;

endmodule

/* src/ccev_div6.sv */
// Back pipeline: signed divide by six toward zero by reciprocal multiply, or pass-through when div6 is clear.
module ccev_div6 (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ccev_pkg::sum_t            in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ccev_pkg::FX_W-1:0] out_value
);
  import ccev_pkg::*;

  logic            mag_valid;
  logic            mag_ready;
  logic [FX_W-1:0] mag;
  logic [FX_W-1:0] mag_next;
  logic            neg;
  logic            neg_next;
  logic [FX_W-1:0] abs_s;
  logic [63:0]     recip_prod;

  logic            res_valid;
  logic            res_ready;
  logic [FX_W-1:0] res;

  assign neg_next   = in_data.div6 && in_data.s[FX_W-1];
  assign abs_s      = in_data.s[FX_W-1] ? (FX_W'(0) - in_data.s) : in_data.s;
  assign recip_prod = 64'(abs_s) * 64'(DIV6_RECIP);
  assign mag_next   = in_data.div6 ? FX_W'(recip_prod >> DIV6_SHIFT) : in_data.s;

  assign mag_ready = !mag_valid || res_ready;
  assign in_ready  = mag_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (mag_ready) begin
      mag_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mag_ready && in_valid) begin
      mag <= mag_next;
      neg <= neg_next;
    end
  end

  assign res_ready = !res_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= mag_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && mag_valid) begin
      res <= neg ? (FX_W'(0) - mag) : mag;
    end
  end

  assign out_valid = res_valid;
  assign out_value = res;

endmodule

/* src/cubic_curve_eval_fx.sv */
// Cubic curve segment evaluator, top level.
// Throughput: one transaction per cycle unless m_tready stalls; seven register
// stages, each with its own valid bit, so bubbles close up and a stall on
// m_tready holds every stage.
// Reset: rst clears all stage valid bits; payload registers are not reset.
module cubic_curve_eval_fx (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // ctrl_p0 [31:0], ctrl_p1 [63:32], ctrl_p2 [95:64], ctrl_p3 [127:96],
  // param_t [140:128], zero [143:141]
  input  logic [ccev_pkg::S_TDATA_W-1:0] s_tdata,
  // mode [2:0]
  input  logic [ccev_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // curve_value [31:0]
  output logic [ccev_pkg::FX_W-1:0]      m_tdata
);
  import ccev_pkg::*;

  logic  front_valid;
  logic  front_ready;
  pow_t  front_data;
  logic  comb_valid;
  logic  comb_ready;
  sum_t  comb_data;

  ccev_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .mode      (mode_t'(s_tuser)),
    .p0        (s_tdata[FX_W-1:0]),
    .p1        (s_tdata[2*FX_W-1:FX_W]),
    .p2        (s_tdata[3*FX_W-1:2*FX_W]),
    .p3        (s_tdata[4*FX_W-1:3*FX_W]),
    .t         (s_tdata[4*FX_W+T_W-1:4*FX_W]),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  ccev_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (comb_valid),
    .out_ready (comb_ready),
    .out_data  (comb_data)
  );

  ccev_div6 u_div6 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (comb_valid),
    .in_ready  (comb_ready),
    .in_data   (comb_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (m_tdata)
  );

endmodule
